[hw/rtl/nps_pkg.sv]
// Shared types and constants for the nine-point stencil matrix-vector unit.
package nps_pkg;

  localparam int POS_W            = 10;
  localparam int VAL_W            = 32;
  localparam int PROD_W           = 2 * VAL_W;
  localparam int FRAC_W           = 16;
  localparam int ACC_W            = 52;
  localparam int ROWS_W           = 11;
  localparam int ROW_W            = 10;
  localparam int VECTOR_DEPTH_DEF = 1024;
  localparam int QUEUE_DEPTH      = 4;

  localparam logic [ROWS_W-1:0] ROWS_RESET = 11'd1024;
  localparam logic [ROWS_W-1:0] ROW_LIMIT  = 11'd1024;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_TAP   = 1'b1;

  // Classified item handed from the front end to the execution side.
  typedef struct packed {
    logic             is_tap;
    logic             in_range;
    logic [POS_W-1:0] position;
    logic [VAL_W-1:0] value;
    logic             last_tap;
  } nps_item_t;

endpackage

[hw/rtl/nps_front.sv]
// Front end: accepts items on the command port and classifies them.
module nps_front #(
  parameter int VECTOR_DEPTH = nps_pkg::VECTOR_DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic                     in_operation,
  input  logic [nps_pkg::POS_W-1:0] in_position,
  input  logic [nps_pkg::VAL_W-1:0] in_value,
  input  logic                     in_last_tap,
  output logic                     push_vld,
  output nps_pkg::nps_item_t       push_item,
  input  logic                     push_rdy
);

  logic               vld_r, vld_nxt;
  nps_pkg::nps_item_t item_r;
  logic               accept;

  assign busy   = vld_r && !push_rdy;
  assign accept = start && !busy;

  always_comb begin
    vld_nxt = vld_r;
    if (accept) begin
      vld_nxt = 1'b1;
    end else if (vld_r && push_rdy) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r.is_tap   <= (in_operation == nps_pkg::OP_TAP);
      // positions past the store are dropped on write and read as zero
      item_r.in_range <= (32'(in_position) < 32'(VECTOR_DEPTH));
      item_r.position <= in_position;
      item_r.value    <= in_value;
      item_r.last_tap <= in_last_tap;
    end
  end

  assign push_vld  = vld_r;
  assign push_item = item_r;

endmodule

[hw/rtl/nps_queue.sv]
// Short item queue between the front end and the execution side.
module nps_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push_vld,
  input  nps_pkg::nps_item_t push_item,
  output logic               push_rdy,
  output logic               pop_vld,
  output nps_pkg::nps_item_t pop_item,
  input  logic               pop_rdy
);

  localparam int PW = $clog2(nps_pkg::QUEUE_DEPTH);
  localparam int CW = $clog2(nps_pkg::QUEUE_DEPTH + 1);

  nps_pkg::nps_item_t slots_r [nps_pkg::QUEUE_DEPTH];
  logic [PW-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic               do_push, do_pop;

  assign push_rdy = (count_r != CW'(nps_pkg::QUEUE_DEPTH));
  assign pop_vld  = (count_r != '0);
  assign pop_item = slots_r[rd_ptr_r];
  assign do_push  = push_vld && push_rdy;
  assign do_pop   = pop_vld && pop_rdy;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + PW'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + PW'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

[hw/rtl/nps_back.sv]
// Execution side: vector store, tap multiply, row accumulate and result output.
module nps_back #(
  parameter int VECTOR_DEPTH = nps_pkg::VECTOR_DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       pop_vld,
  input  nps_pkg::nps_item_t         pop_item,
  output logic                       pop_rdy,
  input  logic                       cfg_write_en,
  input  logic [nps_pkg::ROWS_W-1:0] cfg_write_data,
  output logic                       out_strobe,
  output logic [nps_pkg::ACC_W-1:0]  out_row_sum,
  output logic [nps_pkg::ROW_W-1:0]  out_row_number,
  output logic                       out_last_row
);

  localparam int AW = $clog2(VECTOR_DEPTH);
  localparam int XW = (AW > nps_pkg::POS_W) ? AW : nps_pkg::POS_W;
  localparam int SW = nps_pkg::PROD_W - nps_pkg::FRAC_W;

  logic [nps_pkg::VAL_W-1:0] mem [VECTOR_DEPTH];

  logic [XW-1:0]                    pos_ext;
  logic [AW-1:0]                    idx;
  logic signed [nps_pkg::VAL_W-1:0] rd_data_r;

  logic                             s1_vld_r;
  logic                             s1_in_range_r;
  logic                             s1_last_r;
  logic signed [nps_pkg::VAL_W-1:0] s1_coef_r;
  logic signed [nps_pkg::VAL_W-1:0] s1_elem;

  logic                              s2_vld_r;
  logic                              s2_last_r;
  logic signed [nps_pkg::PROD_W-1:0] prod_r;

  logic [nps_pkg::ACC_W-1:0]  acc_r, acc_nxt;
  logic [nps_pkg::ACC_W-1:0]  sum;
  logic [nps_pkg::ROW_W-1:0]  row_cnt_r, row_cnt_nxt;
  logic [nps_pkg::ROWS_W-1:0] rows_r;
  logic [nps_pkg::ROWS_W-1:0] rows_eff;
  logic                       is_last;
  logic                       emit;
  logic                       strobe_r;
  logic [nps_pkg::ACC_W-1:0]  row_sum_r;
  logic [nps_pkg::ROW_W-1:0]  row_number_r;
  logic                       last_row_r;

  // the back end never stalls, so take the head item every cycle
  assign pop_rdy = 1'b1;
  assign pos_ext = XW'(pop_item.position);
  assign idx     = pos_ext[AW-1:0];

  // stage 0: store write or element read
  always_ff @(posedge clk) begin
    if (pop_vld && !pop_item.is_tap && pop_item.in_range) begin
      mem[idx] <= pop_item.value;
    end
    if (pop_vld && pop_item.is_tap && pop_item.in_range) begin
      rd_data_r <= mem[idx];
    end
  end

  always_ff @(posedge clk) begin
    s1_in_range_r <= pop_item.in_range;
    s1_last_r     <= pop_item.last_tap;
    s1_coef_r     <= pop_item.value;
  end

  // stage 1: multiply
  assign s1_elem = s1_in_range_r ? rd_data_r : '0;

  always_ff @(posedge clk) begin
    prod_r    <= nps_pkg::PROD_W'(s1_coef_r) * nps_pkg::PROD_W'(s1_elem);
    s2_last_r <= s1_last_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= pop_vld && pop_item.is_tap;
      s2_vld_r <= s1_vld_r;
    end
  end

  // stage 2: truncate to Q.16, accumulate, emit on the last tap
  assign sum = acc_r + {{(nps_pkg::ACC_W - SW){prod_r[nps_pkg::PROD_W-1]}},
                        prod_r[nps_pkg::PROD_W-1:nps_pkg::FRAC_W]};

  always_comb begin
    rows_eff = rows_r;
    if (rows_r == '0) begin
      rows_eff = nps_pkg::ROWS_W'(1);
    end else if (rows_r > nps_pkg::ROW_LIMIT) begin
      rows_eff = nps_pkg::ROW_LIMIT;
    end
  end

  assign is_last = ({1'b0, row_cnt_r} + nps_pkg::ROWS_W'(1)) >= rows_eff;
  assign emit    = s2_vld_r && s2_last_r;

  always_comb begin
    acc_nxt     = acc_r;
    row_cnt_nxt = row_cnt_r;
    if (s2_vld_r) begin
      acc_nxt = s2_last_r ? '0 : sum;
    end
    if (emit) begin
      row_cnt_nxt = is_last ? '0 : row_cnt_r + nps_pkg::ROW_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r     <= '0;
      row_cnt_r <= '0;
      rows_r    <= nps_pkg::ROWS_RESET;
      strobe_r  <= 1'b0;
    end else begin
      acc_r     <= acc_nxt;
      row_cnt_r <= row_cnt_nxt;
      strobe_r  <= emit;
      if (cfg_write_en) begin
        rows_r <= cfg_write_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      row_sum_r    <= sum;
      row_number_r <= row_cnt_r;
      last_row_r   <= is_last;
    end
  end

  assign out_strobe     = strobe_r;
  assign out_row_sum    = row_sum_r;
  assign out_row_number = row_number_r;
  assign out_last_row   = last_row_r;

endmodule

[hw/rtl/nine_point_stencil_matvec_unit.sv]
// Top level of the nine-point stencil matrix-vector unit.
//
// Items arrive on the command port: an item is taken at a clock edge with
// start high and busy low. in_operation selects a vector element write or a
// stencil tap; a tap multiplies in_value by the stored element at
// in_position and adds the Q.16 product to the row accumulator. A tap with
// in_last_tap high ends the row: out_strobe rises for one cycle with the row
// sum, its row number and a flag for the last row in use.
// The unit takes one item per cycle. A result reaches the ports after its last
// tap passes the front register and the queue, then the store read, multiply
// and accumulate stages, one stage each.
// The back end drains the queue every cycle, so busy stays low in use; the
// receiver cannot stall and needs no handshake.
// cfg_write_en with cfg_write_data sets the rows in use; write it only while
// the unit is idle. Reset clears the accumulator and the row counter, sets the
// rows in use to 1024 and empties the pipeline; the vector store is not
// cleared and must be written before it is read.
module nine_point_stencil_matvec_unit #(
  parameter int VECTOR_DEPTH = nps_pkg::VECTOR_DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic                       in_operation,
  input  logic [nps_pkg::POS_W-1:0]  in_position,
  input  logic [nps_pkg::VAL_W-1:0]  in_value,
  input  logic                       in_last_tap,
  input  logic                       cfg_write_en,
  input  logic [nps_pkg::ROWS_W-1:0] cfg_write_data,
  output logic                       out_strobe,
  output logic [nps_pkg::ACC_W-1:0]  out_row_sum,
  output logic [nps_pkg::ROW_W-1:0]  out_row_number,
  output logic                       out_last_row
);

  logic               push_vld, push_rdy;
  nps_pkg::nps_item_t push_item;
  logic               pop_vld, pop_rdy;
  nps_pkg::nps_item_t pop_item;

  nps_front #(
    .VECTOR_DEPTH(VECTOR_DEPTH)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_operation(in_operation),
    .in_position (in_position),
    .in_value    (in_value),
    .in_last_tap (in_last_tap),
    .push_vld    (push_vld),
    .push_item   (push_item),
    .push_rdy    (push_rdy)
  );

  nps_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push_vld (push_vld),
    .push_item(push_item),
    .push_rdy (push_rdy),
    .pop_vld  (pop_vld),
    .pop_item (pop_item),
    .pop_rdy  (pop_rdy)
  );

  nps_back #(
    .VECTOR_DEPTH(VECTOR_DEPTH)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .pop_vld       (pop_vld),
    .pop_item      (pop_item),
    .pop_rdy       (pop_rdy),
    .cfg_write_en  (cfg_write_en),
    .cfg_write_data(cfg_write_data),
    .out_strobe    (out_strobe),
    .out_row_sum   (out_row_sum),
    .out_row_number(out_row_number),
    .out_last_row  (out_last_row)
  );

endmodule

[hw/rtl/nps_checker.sv]
// Port-level checks for the stencil unit, bound to its top level.
module nps_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       start,
  input logic                       busy,
  input logic                       in_operation,
  input logic                       in_last_tap,
  input logic                       out_strobe,
  input logic [nps_pkg::ACC_W-1:0]  out_row_sum,
  input logic [nps_pkg::ROW_W-1:0]  out_row_number,
  input logic                       out_last_row
);

  logic row_end;
  logic zero_next_r;

  assign row_end = start && !busy && (in_operation == nps_pkg::OP_TAP) && in_last_tap;

  // the next row is row zero after reset and after the last row
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zero_next_r <= 1'b1;
    end else if (out_strobe) begin
      zero_next_r <= out_last_row;
    end
  end

  // reset empties the pipeline
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_strobe && !busy)
    else $error("result or busy seen right after reset");

  // the queue always drains, so the unit never pushes back
  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy raised although the back end never stalls");

  // every row end gives a result
  a_row_result: assert property (@(posedge clk) disable iff (!rst_n)
    row_end |-> ##5 out_strobe)
    else $error("row end without a result");

  // no result without a row end at the matching earlier edge
  a_no_stray: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(row_end, 5))
    else $error("result without a matching last tap");

  // the first row after reset or after the last row is row zero
  a_row_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && zero_next_r |-> out_row_number == '0)
    else $error("row after reset or after the last row is not row zero");

endmodule

bind nine_point_stencil_matvec_unit nps_checker u_nps_checker (.*);

[bench/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the nine-point stencil matrix-vector unit.
module tb_top;

  localparam int LATENCY_WAIT = 10;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int PHASE_ITEMS  = 170;
  localparam int N_PHASES     = 7;
  localparam int N_DIRECTED   = 21;
  localparam logic [nps_pkg::POS_W-1:0] HEAVY_POS = 10'd1000;

  typedef struct packed {
    logic                      op;
    logic [nps_pkg::POS_W-1:0] pos;
    logic [nps_pkg::VAL_W-1:0] val;
    logic                      last;
  } stencil_item_t;

  typedef struct packed {
    logic [nps_pkg::ACC_W-1:0] sum;
    logic [nps_pkg::ROW_W-1:0] row;
    logic                      last_row;
  } row_result_t;

  typedef struct packed {
    stencil_item_t item;
    logic          typed;
    row_result_t   result;
  } directed_row_t;

  localparam row_result_t NO_CHECK = '0;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       start = 1'b0;
  logic                       busy;
  logic                       in_operation = nps_pkg::OP_WRITE;
  logic [nps_pkg::POS_W-1:0]  in_position = '0;
  logic [nps_pkg::VAL_W-1:0]  in_value = '0;
  logic                       in_last_tap = 1'b0;
  logic                       cfg_write_en = 1'b0;
  logic [nps_pkg::ROWS_W-1:0] cfg_write_data = '0;
  logic                       out_strobe;
  logic [nps_pkg::ACC_W-1:0]  out_row_sum;
  logic [nps_pkg::ROW_W-1:0]  out_row_number;
  logic                       out_last_row;

  // Shadow copy of the unit's state
  logic [nps_pkg::VAL_W-1:0]  shadow_vec [nps_pkg::VECTOR_DEPTH_DEF];
  bit                         vec_written [nps_pkg::VECTOR_DEPTH_DEF];
  int                         written_pos [$];
  logic [nps_pkg::ACC_W-1:0]  shadow_acc = '0;
  logic [nps_pkg::ROW_W-1:0]  shadow_row = '0;
  logic [nps_pkg::ROWS_W-1:0] shadow_rows = nps_pkg::ROWS_RESET;

  row_result_t        pending_sums [$];
  row_result_t        head_sum;
  directed_row_t      directed_rows [N_DIRECTED];
  int                 mismatch_count = 0;
  int                 rows_checked = 0;
  int                 items_sent = 0;
  int                 cycle_count = 0;
  bit                 idle_on = 1'b1;

  nine_point_stencil_matvec_unit DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_operation   (in_operation),
    .in_position    (in_position),
    .in_value       (in_value),
    .in_last_tap    (in_last_tap),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .out_strobe     (out_strobe),
    .out_row_sum    (out_row_sum),
    .out_row_number (out_row_number),
    .out_last_row   (out_last_row)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: cycle limit reached with %0d row sums outstanding", $time,
               pending_sums.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  // Apply one item to the shadow state; return 1 when it closes a row.
  function automatic bit accumulate_item(input stencil_item_t it, output row_result_t res);
    logic signed [nps_pkg::PROD_W-1:0] coef;
    logic signed [nps_pkg::PROD_W-1:0] elem;
    logic signed [nps_pkg::PROD_W-1:0] prod;
    logic signed [nps_pkg::PROD_W-1:0] shifted;
    int eff_rows;
    bit is_last;
    res = '0;
    if (it.op == nps_pkg::OP_WRITE) begin
      shadow_vec[it.pos] = it.val;
      if (!vec_written[it.pos]) begin
        vec_written[it.pos] = 1'b1;
        written_pos.push_back(int'(it.pos));
      end
      return 1'b0;
    end
    coef = {{nps_pkg::VAL_W{it.val[nps_pkg::VAL_W-1]}}, it.val};
    elem = {{nps_pkg::VAL_W{shadow_vec[it.pos][nps_pkg::VAL_W-1]}}, shadow_vec[it.pos]};
    prod = coef * elem;
    shifted = prod >>> nps_pkg::FRAC_W;
    shadow_acc = shadow_acc + shifted[nps_pkg::ACC_W-1:0];
    if (!it.last) return 1'b0;
    if (shadow_rows == '0) eff_rows = 1;
    else if (shadow_rows > nps_pkg::ROW_LIMIT) eff_rows = int'(nps_pkg::ROW_LIMIT);
    else eff_rows = int'(shadow_rows);
    is_last = (int'(shadow_row) + 1 >= eff_rows);
    res.sum = shadow_acc;
    res.row = shadow_row;
    res.last_row = is_last;
    shadow_acc = '0;
    shadow_row = is_last ? '0 : shadow_row + 1'b1;
    return 1'b1;
  endfunction

  function automatic logic [nps_pkg::VAL_W-1:0] rand_value();
    case ($urandom_range(0, 9))
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      2: return 32'h00000000;
      3: return 32'hFFFFFFFF;
      4: return {{16{1'b0}}, 16'($urandom)};
      5: return {{16{1'b1}}, 16'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  function automatic int pick_gap();
    if (!idle_on) return 0;
    return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
  endfunction

  // Drive one item, hold it until taken, then record what it should produce.
  task automatic send_item(input stencil_item_t it, input int gap, input bit use_typed,
                           input row_result_t typed_res);
    row_result_t res;
    bit has_res;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_operation <= it.op;
    in_position  <= it.pos;
    in_value     <= it.val;
    in_last_tap  <= it.last;
    start        <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    has_res = accumulate_item(it, res);
    if (has_res) pending_sums.push_back(use_typed ? typed_res : res);
    items_sent++;
  endtask

  task automatic hold_until_drained();
    start <= 1'b0;
    @(posedge clk);
    while (pending_sums.size() != 0) @(posedge clk);
  endtask

  task automatic set_rows_in_use(input logic [nps_pkg::ROWS_W-1:0] rows);
    hold_until_drained();
    // writes and open rows leave no result behind, so give the pipe time to empty
    repeat (LATENCY_WAIT) @(posedge clk);
    cfg_write_data <= rows;
    cfg_write_en   <= 1'b1;
    @(posedge clk);
    cfg_write_en   <= 1'b0;
    shadow_rows = rows;
  endtask

  task automatic run_random(input int n_items, input bit allow_idle, input bit pause_mid);
    stencil_item_t it;
    int sent;
    int row_len;
    bit heavy;
    bit paused;
    sent = 0;
    paused = 1'b0;
    idle_on = allow_idle;
    while (sent < n_items) begin
      if (allow_idle && $urandom_range(0, 5) == 0) idle_on = !idle_on;
      if (pause_mid && !paused && sent >= n_items / 2) begin
        hold_until_drained();
        paused = 1'b1;
      end
      repeat ($urandom_range(0, 3)) begin
        it.op   = nps_pkg::OP_WRITE;
        it.pos  = nps_pkg::POS_W'($urandom_range(0, nps_pkg::VECTOR_DEPTH_DEF - 1));
        it.val  = rand_value();
        it.last = 1'($urandom_range(0, 1));
        send_item(it, pick_gap(), 1'b0, NO_CHECK);
        sent++;
      end
      heavy = 1'b0;
      case ($urandom_range(0, 19))
        0: row_len = $urandom_range(1, 8);
        1: row_len = $urandom_range(10, 16);
        2: begin
          // long row of maximal products: wraps the accumulator
          heavy = 1'b1;
          row_len = 40;
          it.op   = nps_pkg::OP_WRITE;
          it.pos  = HEAVY_POS;
          it.val  = 32'h80000000;
          it.last = 1'b0;
          send_item(it, pick_gap(), 1'b0, NO_CHECK);
          sent++;
        end
        default: row_len = 9;
      endcase
      for (int k = 0; k < row_len; k++) begin
        it.op = nps_pkg::OP_TAP;
        if (heavy) begin
          it.pos = HEAVY_POS;
          it.val = 32'h80000000;
        end else begin
          it.pos = nps_pkg::POS_W'(written_pos[$urandom_range(0, written_pos.size() - 1)]);
          // centre tap reads the row's own element when it exists
          if (k == row_len / 2 && vec_written[shadow_row]) it.pos = shadow_row;
          it.val = rand_value();
        end
        it.last = (k == row_len - 1);
        send_item(it, pick_gap(), 1'b0, NO_CHECK);
        sent++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      if (pending_sums.size() == 0) begin
        $display("%0t: row sum with none expected: sum=%h row=%0d last=%b", $time,
                 out_row_sum, out_row_number, out_last_row);
        mismatch_count++;
      end else begin
        head_sum = pending_sums.pop_front();
        rows_checked++;
        if (out_row_sum !== head_sum.sum) begin
          $display("%0t: row_sum expected %h actual %h", $time, head_sum.sum, out_row_sum);
          mismatch_count++;
        end
        if (out_row_number !== head_sum.row) begin
          $display("%0t: row_number expected %0d actual %0d", $time, head_sum.row,
                   out_row_number);
          mismatch_count++;
        end
        if (out_last_row !== head_sum.last_row) begin
          $display("%0t: last_row expected %b actual %b", $time, head_sum.last_row,
                   out_last_row);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    logic [nps_pkg::ROWS_W-1:0] phase_rows [N_PHASES];
    directed_rows = '{
      {nps_pkg::OP_WRITE, 10'd0,    32'h00010000, 1'b0, 1'b0, NO_CHECK},
      {nps_pkg::OP_WRITE, 10'd1023, 32'h7FFFFFFF, 1'b0, 1'b0, NO_CHECK},
      {nps_pkg::OP_WRITE, 10'd512,  32'h80000000, 1'b0, 1'b0, NO_CHECK},
      {nps_pkg::OP_WRITE, 10'd5,    32'hFFFF0000, 1'b1, 1'b0, NO_CHECK},
      {nps_pkg::OP_WRITE, 10'd7,    32'hFFFFFFFF, 1'b0, 1'b0, NO_CHECK},
      {nps_pkg::OP_TAP,   10'd0,    32'h00010000, 1'b1, 1'b1, 52'h0000000010000, 10'd0, 1'b0},
      {nps_pkg::OP_TAP,   10'd1023, 32'h7FFFFFFF, 1'b1, 1'b0, NO_CHECK},
      {nps_pkg::OP_TAP,   10'd512,  32'h80000000, 1'b1, 1'b1, 52'h0400000000000, 10'd2, 1'b0},
      {nps_pkg::OP_TAP,   10'd512,  32'h7FFFFFFF, 1'b1, 1'b0, NO_CHECK},
      {nps_pkg::OP_TAP,   10'd5,    32'h00000001, 1'b1, 1'b1, 52'hFFFFFFFFFFFFF, 10'd4, 1'b0},
      {nps_pkg::OP_TAP,   10'd7,    32'h00000001, 1'b1, 1'b1, 52'hFFFFFFFFFFFFF, 10'd5, 1'b0},
      {nps_pkg::OP_TAP,   10'd0,    32'h00000000, 1'b1, 1'b1, 52'h0000000000000, 10'd6, 1'b0},
      {nps_pkg::OP_TAP,   10'd0,    32'h00020000, 1'b0, 1'b0, NO_CHECK},
      {nps_pkg::OP_TAP,   10'd1023, 32'h80000000, 1'b0, 1'b0, NO_CHECK},
      {nps_pkg::OP_TAP,   10'd512,  32'h80000000, 1'b0, 1'b0, NO_CHECK},
      {nps_pkg::OP_TAP,   10'd5,    32'h7FFFFFFF, 1'b0, 1'b0, NO_CHECK},
      {nps_pkg::OP_TAP,   10'd7,    32'h12345678, 1'b0, 1'b0, NO_CHECK},
      {nps_pkg::OP_TAP,   10'd0,    32'hFFFF0000, 1'b0, 1'b0, NO_CHECK},
      {nps_pkg::OP_TAP,   10'd1023, 32'h7FFFFFFF, 1'b0, 1'b0, NO_CHECK},
      {nps_pkg::OP_TAP,   10'd512,  32'hFFFFFFFF, 1'b0, 1'b0, NO_CHECK},
      {nps_pkg::OP_TAP,   10'd5,    32'h00008000, 1'b1, 1'b0, NO_CHECK}
    };
    // reset value first, then the extremes, then a small random row count
    phase_rows = '{nps_pkg::ROWS_RESET, 11'd2, 11'd0, 11'd1, 11'd2047, 11'd1024, 11'd0};
    phase_rows[N_PHASES-1] = nps_pkg::ROWS_W'($urandom_range(3, 12));

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < N_DIRECTED; i++) begin
      send_item(directed_rows[i].item, pick_gap(), directed_rows[i].typed,
                directed_rows[i].result);
    end

    for (int p = 0; p < N_PHASES; p++) begin
      // rows in use of 2 lands below the counter left by the directed rows
      if (p > 0) set_rows_in_use(phase_rows[p]);
      run_random(PHASE_ITEMS, p != N_PHASES - 1, p == 1);
    end

    hold_until_drained();
    repeat (LATENCY_WAIT) @(posedge clk);
    $display("Sent %0d items and checked %0d row sums across %0d row-count settings,",
             items_sent, rows_checked, N_PHASES);
    $display("including counter wrap, lowered row counts and accumulator wrap.");
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
